>>> hw/rtl/hhs_pkg.sv
// ----------------------------------------------------------------------------
// hhs_pkg
// Types, register map and reset values for the heading hold spin controller.
// ----------------------------------------------------------------------------
package hhs_pkg;

	localparam int unsigned AddrW = 5;

	localparam logic [2:0] REG_PROP_GAIN      = 3'd0;
	localparam logic [2:0] REG_INTEG_GAIN     = 3'd1;
	localparam logic [2:0] REG_DERIV_GAIN     = 3'd2;
	localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd3;
	localparam logic [2:0] REG_SPIN_STEP      = 3'd4;
	localparam logic [2:0] REG_SPIN_LIMIT     = 3'd5;

	localparam logic [9:0]  RST_PROP_GAIN      = 10'd60;
	localparam logic [9:0]  RST_INTEG_GAIN     = 10'd0;
	localparam logic [9:0]  RST_DERIV_GAIN     = 10'd30;
	localparam logic [19:0] RST_INTEGRAL_LIMIT = 20'd3200;
	localparam logic [14:0] RST_SPIN_STEP      = 15'd5;
	localparam logic [14:0] RST_SPIN_LIMIT     = 15'd300;

	typedef struct packed {
		logic               remote_mode;
		logic signed [15:0] lin_vx;
		logic signed [15:0] lin_vy;
		logic signed [15:0] spin_request;
		logic signed [23:0] heading;
	} hhs_cmd_t;

	typedef struct packed {
		logic signed [15:0] out_vx;
		logic signed [15:0] out_vy;
		logic signed [15:0] out_spin;
	} hhs_res_t;

	typedef struct packed {
		logic [9:0]  prop_gain;
		logic [9:0]  integ_gain;
		logic [9:0]  deriv_gain;
		logic [19:0] integral_limit;
		logic [14:0] spin_step;
		logic [14:0] spin_limit;
	} hhs_cfg_t;

	typedef struct packed {
		logic               hold;
		logic signed [15:0] ramp_spin;
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic signed [24:0] err;
		logic signed [31:0] integ;
		logic signed [25:0] derr;
	} hhs_upd_t;

	typedef struct packed {
		logic               valid;
		logic               hold;
	} hhs_stat_t;

endpackage

>>> hw/rtl/hhs_regs.sv
// ----------------------------------------------------------------------------
// hhs_regs
// APB register file holding the gains, limits and ramp step.
// ----------------------------------------------------------------------------
module hhs_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [hhs_pkg::AddrW-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output hhs_pkg::hhs_cfg_t         cfg
);

	hhs_pkg::hhs_cfg_t cfg_q;
	logic [2:0]        idx;
	logic              wr;

	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain      <= hhs_pkg::RST_PROP_GAIN;
			cfg_q.integ_gain     <= hhs_pkg::RST_INTEG_GAIN;
			cfg_q.deriv_gain     <= hhs_pkg::RST_DERIV_GAIN;
			cfg_q.integral_limit <= hhs_pkg::RST_INTEGRAL_LIMIT;
			cfg_q.spin_step      <= hhs_pkg::RST_SPIN_STEP;
			cfg_q.spin_limit     <= hhs_pkg::RST_SPIN_LIMIT;
		end else if (wr) begin
			case (idx)
				hhs_pkg::REG_PROP_GAIN:      cfg_q.prop_gain      <= pwdata[9:0];
				hhs_pkg::REG_INTEG_GAIN:     cfg_q.integ_gain     <= pwdata[9:0];
				hhs_pkg::REG_DERIV_GAIN:     cfg_q.deriv_gain     <= pwdata[9:0];
				hhs_pkg::REG_INTEGRAL_LIMIT: cfg_q.integral_limit <= pwdata[19:0];
				hhs_pkg::REG_SPIN_STEP:      cfg_q.spin_step      <= pwdata[14:0];
				hhs_pkg::REG_SPIN_LIMIT:     cfg_q.spin_limit     <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			hhs_pkg::REG_PROP_GAIN:      prdata = {22'd0, cfg_q.prop_gain};
			hhs_pkg::REG_INTEG_GAIN:     prdata = {22'd0, cfg_q.integ_gain};
			hhs_pkg::REG_DERIV_GAIN:     prdata = {22'd0, cfg_q.deriv_gain};
			hhs_pkg::REG_INTEGRAL_LIMIT: prdata = {12'd0, cfg_q.integral_limit};
			hhs_pkg::REG_SPIN_STEP:      prdata = {17'd0, cfg_q.spin_step};
			hhs_pkg::REG_SPIN_LIMIT:     prdata = {17'd0, cfg_q.spin_limit};
			default:                     prdata = 32'd0;
		endcase
	end

endmodule

>>> hw/rtl/hhs_state.sv
// ----------------------------------------------------------------------------
// hhs_state
// Spin ramp, target capture and PID error/integral update, one request per
// cycle while stage two loads; update fields are registered into stage two.
// ----------------------------------------------------------------------------
module hhs_state (
	input  logic              clk,
	input  logic              arst_n,
	input  hhs_pkg::hhs_cmd_t cmd_s1,
	input  logic              adv,
	input  logic              load_s2,
	input  hhs_pkg::hhs_cfg_t cfg,
	output hhs_pkg::hhs_upd_t upd_s2
);

	logic signed [15:0] ramped_q;
	logic signed [23:0] target_q;
	logic signed [31:0] integ_q;
	logic signed [24:0] last_err_q;

	logic               ramp_act;
	logic signed [16:0] rdiff;
	logic        [16:0] rmag;
	logic signed [15:0] ramp_nx;
	logic signed [23:0] target_nx;
	logic signed [24:0] err;
	logic signed [32:0] isum;
	logic signed [32:0] ilim;
	logic signed [31:0] integ_nx;
	logic signed [25:0] derr;
	hhs_pkg::hhs_upd_t  upd;

	always_comb begin
		ramp_act = (cmd_s1.spin_request != 16'sd0) || (ramped_q != 16'sd0);
		rdiff    = 17'(cmd_s1.spin_request) - 17'(ramped_q);
		rmag     = rdiff[16] ? 17'(-rdiff) : 17'(rdiff);
		if (rmag > {2'b00, cfg.spin_step}) begin
			if (rdiff > 17'sd0) begin
				ramp_nx = ramped_q + $signed({1'b0, cfg.spin_step});
			end else begin
				ramp_nx = ramped_q - $signed({1'b0, cfg.spin_step});
			end
		end else begin
			ramp_nx = cmd_s1.spin_request;
		end
		target_nx = (ramp_nx == 16'sd0) ? cmd_s1.heading : target_q;

		err  = 25'(cmd_s1.heading) - 25'(target_q);
		isum = 33'(integ_q) + 33'(err);
		ilim = $signed({13'd0, cfg.integral_limit});
		if (cfg.integral_limit != 20'd0) begin
			if (isum > ilim) begin
				integ_nx = 32'(ilim);
			end else if (isum < -ilim) begin
				integ_nx = 32'(-ilim);
			end else begin
				integ_nx = isum[31:0];
			end
		end else begin
			if (isum > 33'sh0_7FFF_FFFF) begin
				integ_nx = 32'sh7FFF_FFFF;
			end else if (isum < -33'sh0_8000_0000) begin
				integ_nx = 32'sh8000_0000;
			end else begin
				integ_nx = isum[31:0];
			end
		end
		derr = 26'(err) - 26'(last_err_q);

		upd.hold      = !ramp_act;
		upd.ramp_spin = ramp_nx;
		upd.vx        = cmd_s1.lin_vx;
		upd.vy        = cmd_s1.lin_vy;
		upd.err       = err;
		upd.integ     = integ_nx;
		upd.derr      = derr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramped_q   <= '0;
			target_q   <= '0;
			integ_q    <= '0;
			last_err_q <= '0;
		end else if (adv) begin
			if (ramp_act) begin
				ramped_q <= ramp_nx;
				target_q <= target_nx;
			end else begin
				integ_q    <= integ_nx;
				last_err_q <= err;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			upd_s2 <= upd;
		end
	end

endmodule

>>> hw/rtl/hhs_pid.sv
// ----------------------------------------------------------------------------
// hhs_pid
// PID products registered in stage three, then sum, divide by 16 toward
// zero and clamp to the spin limit; the ramp spin is used outside hold.
// ----------------------------------------------------------------------------
module hhs_pid (
	input  logic              clk,
	input  hhs_pkg::hhs_upd_t upd_s2,
	input  logic              load_s3,
	input  hhs_pkg::hhs_cfg_t cfg,
	output hhs_pkg::hhs_res_t res,
	output logic              hold
);

	logic               hold_s3;
	logic signed [15:0] ramp_s3;
	logic signed [15:0] vx_s3;
	logic signed [15:0] vy_s3;
	logic signed [35:0] pp_s3;
	logic signed [42:0] pi_s3;
	logic signed [36:0] pd_s3;

	logic signed [43:0] u;
	logic signed [43:0] ub;
	logic signed [39:0] q;
	logic signed [39:0] lim;
	logic signed [15:0] pid_spin;

	always_ff @(posedge clk) begin
		if (load_s3) begin
			hold_s3 <= upd_s2.hold;
			ramp_s3 <= upd_s2.ramp_spin;
			vx_s3   <= upd_s2.vx;
			vy_s3   <= upd_s2.vy;
			pp_s3   <= $signed({1'b0, cfg.prop_gain}) * upd_s2.err;
			pi_s3   <= $signed({1'b0, cfg.integ_gain}) * upd_s2.integ;
			pd_s3   <= $signed({1'b0, cfg.deriv_gain}) * upd_s2.derr;
		end
	end

	always_comb begin
		u   = 44'(pp_s3) + 44'(pi_s3) + 44'(pd_s3);
		ub  = u[43] ? (u + 44'sd15) : u;
		q   = 40'(ub >>> 4);
		lim = $signed({25'd0, cfg.spin_limit});
		if (q > lim) begin
			pid_spin = 16'(lim);
		end else if (q < -lim) begin
			pid_spin = 16'(-lim);
		end else begin
			pid_spin = q[15:0];
		end
		res.out_vx   = vx_s3;
		res.out_vy   = vy_s3;
		res.out_spin = hold_s3 ? pid_spin : ramp_s3;
		hold         = hold_s3;
	end

endmodule

>>> hw/rtl/heading_hold_spin_controller.sv
// ----------------------------------------------------------------------------
// heading_hold_spin_controller
// Remote command pass-through with slew-limited spin ramp and PID heading hold.
//
//   channel  dir  handshake                   payload
//   cmd      in   cmd_valid / cmd_ready       hhs_cmd_t
//   res      out  res_valid / res_ready       hhs_res_t
//   apb      in   psel penable pwrite pready  paddr pwdata prdata
//
// A request is taken every cycle unless all stages are full under a stalled
// output; its result passes the input register, state update, product
// registers and output register. Each stage advances when empty or when
// the stage after it advances, so bubbles close up under a stalled output.
// Requests with remote_mode low are dropped after the input register. Reset
// clears valid flags, ramp, target and PID state and loads register defaults.
// ----------------------------------------------------------------------------
module heading_hold_spin_controller (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	output logic                      cmd_ready,
	input  hhs_pkg::hhs_cmd_t         cmd,
	output logic                      res_valid,
	input  logic                      res_ready,
	output hhs_pkg::hhs_res_t         res,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [hhs_pkg::AddrW-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	hhs_pkg::hhs_cfg_t  cfg;
	hhs_pkg::hhs_cmd_t  cmd_s1;
	hhs_pkg::hhs_upd_t  upd_s2;
	hhs_pkg::hhs_res_t  res_c;
	hhs_pkg::hhs_res_t  res_q;
	hhs_pkg::hhs_stat_t st_s3;
	logic               v_s1;
	logic               v_s2;
	logic               v_s3;
	logic               res_valid_q;
	logic               load_out;
	logic               load_s3;
	logic               load_s2;
	logic               load_s1;
	logic               adv;
	logic               hold_s3;

	assign load_out  = !res_valid_q || res_ready;
	assign load_s3   = !v_s3 || load_out;
	assign load_s2   = !v_s2 || load_s3;
	assign load_s1   = !v_s1 || load_s2;
	assign cmd_ready = load_s1;
	assign adv       = v_s1 && cmd_s1.remote_mode && load_s2;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign st_s3     = '{valid: v_s3, hold: hold_s3};

	hhs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hhs_state u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_s1  (cmd_s1),
		.adv     (adv),
		.load_s2 (load_s2),
		.cfg     (cfg),
		.upd_s2  (upd_s2)
	);

	hhs_pid u_pid (
		.clk     (clk),
		.upd_s2  (upd_s2),
		.load_s3 (load_s3),
		.cfg     (cfg),
		.res     (res_c),
		.hold    (hold_s3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				v_s1 <= cmd_valid;
			end
			if (load_s2) begin
				v_s2 <= v_s1 && cmd_s1.remote_mode;
			end
			if (load_s3) begin
				v_s3 <= v_s2;
			end
			if (load_out) begin
				res_valid_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			cmd_s1 <= cmd;
		end
		if (load_out) begin
			res_q <= res_c;
		end
	end

`ifndef SYNTHESIS
	a_ready_when_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid_q |-> cmd_ready)
		else $error("cmd_ready low with empty output register");

	a_out_from_s3: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(v_s3))
		else $error("result appeared without a stage three request");

	a_hold_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(st_s3.valid && st_s3.hold) |->
		(($signed(res_c.out_spin) <= $signed({1'b0, cfg.spin_limit})) &&
		 ($signed(res_c.out_spin) >= -$signed({1'b0, cfg.spin_limit}))))
		else $error("hold spin outside spin limit");
`endif

endmodule

>>> bench/hhs_spin_checker.sv
// ----------------------------------------------------------------------------
// hhs_spin_checker
// Watches the command, result and register ports of the heading hold spin
// controller. Tracks the register writes, predicts the drive command for
// every accepted remote request and compares each result, field by field,
// against the oldest prediction still pending.
// ----------------------------------------------------------------------------
module hhs_spin_checker
	import hhs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  logic                 cmd_ready,
	input  hhs_cmd_t             cmd,
	input  logic                 res_valid,
	input  logic                 res_ready,
	input  hhs_res_t             res,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic                 pready,
	input  logic [AddrW-1:0]     paddr,
	input  logic [31:0]          pwdata,
	output int unsigned          outstanding,
	output int unsigned          errors
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam longint SUM_MAX = 64'sd2147483647;
	localparam longint SUM_MIN = -64'sd2147483648;

	hhs_cfg_t           gains;
	logic signed [15:0] ramp_now;
	logic signed [23:0] hold_target;
	logic signed [31:0] err_sum;
	logic signed [24:0] prev_err;
	hhs_res_t           due_drive_cmds [$];
	hhs_res_t           oldest;
	int unsigned        fault_count = 0;

	assign errors = fault_count;

	task automatic log_fault(input string msg);
		$display("%0t spin checker: %s", $realtime, msg);
		fault_count++;
	endtask

	task automatic check_field(input string name, input longint got, input longint want);
		if (got != want) begin
			log_fault($sformatf("%s got %0d want %0d", name, got, want));
		end
	endtask

	function automatic hhs_res_t advance_heading_hold(input hhs_cmd_t c);
		hhs_res_t r;
		longint   gap;
		longint   err;
		longint   sum;
		longint   derr;
		longint   drive;
		longint   lim;
		r.out_vx = c.lin_vx;
		r.out_vy = c.lin_vy;
		if (c.spin_request != 0 || ramp_now != 0) begin
			gap = longint'(c.spin_request) - longint'(ramp_now);
			if ((gap < 0 ? -gap : gap) > longint'(gains.spin_step)) begin
				if (gap > 0) begin
					ramp_now = 16'(longint'(ramp_now) + longint'(gains.spin_step));
				end else begin
					ramp_now = 16'(longint'(ramp_now) - longint'(gains.spin_step));
				end
			end else begin
				ramp_now = c.spin_request;
			end
			r.out_spin = ramp_now;
			if (ramp_now == 0) begin
				hold_target = c.heading;
			end
		end else begin
			err = longint'(c.heading) - longint'(hold_target);
			sum = longint'(err_sum) + err;
			if (gains.integral_limit != 0) begin
				lim = longint'(gains.integral_limit);
				if (sum > lim) sum = lim;
				else if (sum < -lim) sum = -lim;
			end else begin
				if (sum > SUM_MAX) sum = SUM_MAX;
				else if (sum < SUM_MIN) sum = SUM_MIN;
			end
			err_sum = 32'(sum);
			derr = err - longint'(prev_err);
			prev_err = 25'(err);
			drive = longint'(gains.prop_gain) * err
				+ longint'(gains.integ_gain) * longint'(err_sum)
				+ longint'(gains.deriv_gain) * derr;
			drive = drive / 16;
			lim = longint'(gains.spin_limit);
			if (drive > lim) drive = lim;
			else if (drive < -lim) drive = -lim;
			r.out_spin = 16'(drive);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains.prop_gain      = RST_PROP_GAIN;
			gains.integ_gain     = RST_INTEG_GAIN;
			gains.deriv_gain     = RST_DERIV_GAIN;
			gains.integral_limit = RST_INTEGRAL_LIMIT;
			gains.spin_step      = RST_SPIN_STEP;
			gains.spin_limit     = RST_SPIN_LIMIT;
			ramp_now    = '0;
			hold_target = '0;
			err_sum     = '0;
			prev_err    = '0;
			due_drive_cmds.delete();
			outstanding <= 0;
		end else begin
			if (res_valid && res_ready) begin
				if (due_drive_cmds.size() == 0) begin
					log_fault("result with no request pending");
				end else begin
					oldest = due_drive_cmds.pop_front();
					check_field("out_vx", res.out_vx, oldest.out_vx);
					check_field("out_vy", res.out_vy, oldest.out_vy);
					check_field("out_spin", res.out_spin, oldest.out_spin);
				end
			end
			if (cmd_valid && cmd_ready && cmd.remote_mode) begin
				due_drive_cmds.push_back(advance_heading_hold(cmd));
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[AddrW-1:2])
					REG_PROP_GAIN:      gains.prop_gain      = pwdata[9:0];
					REG_INTEG_GAIN:     gains.integ_gain     = pwdata[9:0];
					REG_DERIV_GAIN:     gains.deriv_gain     = pwdata[9:0];
					REG_INTEGRAL_LIMIT: gains.integral_limit = pwdata[19:0];
					REG_SPIN_STEP:      gains.spin_step      = pwdata[14:0];
					REG_SPIN_LIMIT:     gains.spin_limit     = pwdata[14:0];
					default: begin
					end
				endcase
			end
			outstanding <= due_drive_cmds.size();
		end
	end

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the heading hold spin controller: a directed run at reset
// settings, then phases of random ramp and heading hold traffic under
// several register settings and pacing mixes, with integral windup runs.
// Checking is done by hhs_spin_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

	import hhs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LAT_PAD        = 8;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned PHASE_ITEMS    = 50;
	localparam int unsigned WINDUP_ITEMS   = 135;

	localparam logic [2:0] REG_NONE_A = 3'd6;
	localparam logic [2:0] REG_NONE_B = 3'd7;

	localparam logic signed [23:0] HEADING_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] HEADING_MIN = 24'sh800000;

	localparam int PACE_FREE   = 0;
	localparam int PACE_GAPS   = 1;
	localparam int PACE_STALLS = 2;
	localparam int PACE_MIXED  = 3;

	localparam int SET_RANDOM = 0;
	localparam int SET_MAX    = 1;
	localparam int SET_ZERO   = 2;
	localparam int SET_WINDUP = 3;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cmd_valid;
	logic               cmd_ready;
	hhs_cmd_t           cmd;
	logic               res_valid;
	logic               res_ready = 1'b0;
	hhs_res_t           res;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [AddrW-1:0]   paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	int unsigned        outstanding;
	int unsigned        errors;
	int unsigned        sender_gap_pct = 0;
	int unsigned        sink_stall_pct = 0;
	int unsigned        quiet_cycles = 0;
	logic signed [23:0] heading_aim = '0;

	always #1ns clk = ~clk;

	heading_hold_spin_controller u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	hhs_spin_checker u_spin_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.outstanding (outstanding),
		.errors      (errors)
	);

	always @(posedge clk) begin
		res_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && cmd_ready) || (res_valid && res_ready) || (psel && penable)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic hhs_cmd_t make_cmd(input logic mode, input logic signed [15:0] vx,
			input logic signed [15:0] vy, input logic signed [15:0] req,
			input logic signed [23:0] hd);
		hhs_cmd_t c;
		c.remote_mode  = mode;
		c.lin_vx       = vx;
		c.lin_vy       = vy;
		c.spin_request = req;
		c.heading      = hd;
		return c;
	endfunction

	function automatic hhs_cmd_t random_cmd();
		return make_cmd(1'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
			24'($urandom()));
	endfunction

	function automatic logic signed [15:0] pick_request();
		logic signed [15:0] r;
		if ($urandom_range(0, 9) < 7) begin
			r = 16'($urandom_range(1, 64));
			if ($urandom_range(0, 1) == 1) r = -r;
		end else begin
			r = 16'($urandom());
		end
		return r;
	endfunction

	function automatic logic signed [23:0] next_heading();
		if ($urandom_range(0, 19) == 0) begin
			heading_aim = 24'($urandom());
		end else begin
			heading_aim = heading_aim + 24'(int'($urandom_range(0, 8)) - 4);
		end
		if ($urandom_range(0, 49) == 0) begin
			return ($urandom_range(0, 1) == 1) ? HEADING_MAX : HEADING_MIN;
		end
		return heading_aim + 24'(int'($urandom_range(0, 64)) - 32);
	endfunction

	task automatic push_cmd(input hhs_cmd_t c);
		while ($urandom_range(0, 99) < sender_gap_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
	endtask

	task automatic program_reg(input logic [2:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
	endtask

	task automatic wait_quiet();
		cmd_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (LAT_PAD) @(posedge clk);
	endtask

	task automatic load_settings(input int kind, input bit zero_step);
		logic [31:0] v [6];
		foreach (v[i]) v[i] = $urandom();
		case (kind)
			SET_RANDOM: begin
				v[4] = (v[4] & 32'hFFFF_8000) | 32'($urandom_range(1, 400));
			end
			SET_MAX: begin
				foreach (v[i]) v[i] = 32'hFFFF_FFFF;
			end
			SET_ZERO: begin
				v[0] = v[0] << 10;
				v[1] = v[1] << 10;
				v[2] = v[2] << 10;
				v[3] = v[3] << 20;
				v[4] = zero_step ? (v[4] << 15) : (v[4] | 32'h7FFF);
				v[5] = v[5] << 15;
			end
			SET_WINDUP: begin
				v[1] = 32'($urandom_range(1, 1023));
				v[3] = v[3] << 20;
				v[4] = v[4] | 32'h7FFF;
			end
			default: begin
			end
		endcase
		program_reg(REG_PROP_GAIN, v[0]);
		program_reg(REG_NONE_A, $urandom());
		program_reg(REG_INTEG_GAIN, v[1]);
		program_reg(REG_DERIV_GAIN, v[2]);
		program_reg(REG_INTEGRAL_LIMIT, v[3]);
		program_reg(REG_SPIN_STEP, v[4]);
		program_reg(REG_NONE_B, $urandom());
		program_reg(REG_SPIN_LIMIT, v[5]);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_pace(input int pace);
		case (pace)
			PACE_FREE:   begin sender_gap_pct = 0;  sink_stall_pct = 0;  end
			PACE_GAPS:   begin sender_gap_pct = 52; sink_stall_pct = 0;  end
			PACE_STALLS: begin sender_gap_pct = 0;  sink_stall_pct = 52; end
			default:     begin sender_gap_pct = 9;  sink_stall_pct = 9;  end
		endcase
	endtask

	// capture the target at one heading extreme, then hold at the other
	task automatic wind_integral(input bit upward);
		logic signed [23:0] from;
		logic signed [23:0] to;
		from = upward ? HEADING_MIN : HEADING_MAX;
		to   = upward ? HEADING_MAX : HEADING_MIN;
		repeat (3) push_cmd(make_cmd(1'b1, 16'($urandom()), 16'($urandom()), 16'sd0, from));
		push_cmd(make_cmd(1'b1, 16'($urandom()), 16'($urandom()), 16'sd1, from));
		push_cmd(make_cmd(1'b1, 16'($urandom()), 16'($urandom()), 16'sd0, from));
		repeat (WINDUP_ITEMS) begin
			push_cmd(make_cmd(1'b1, 16'($urandom()), 16'($urandom()), 16'sd0, to));
		end
	endtask

	task automatic run_traffic(input int unsigned quota);
		int unsigned        sent;
		int unsigned        len;
		int unsigned        pick;
		logic signed [15:0] req;
		hhs_cmd_t           c;
		sent = 0;
		while (sent < quota) begin
			pick = $urandom_range(0, 99);
			req  = (pick < 40) ? pick_request() : 16'sd0;
			len  = (pick < 40) ? $urandom_range(1, 8) : (pick < 90) ? $urandom_range(3, 30) : 1;
			repeat (len) begin
				if ($urandom_range(0, 9) == 0) begin
					c = random_cmd();
					c.remote_mode = 1'b0;
					push_cmd(c);
				end
				if (pick >= 90) begin
					c = random_cmd();
				end else begin
					if (pick < 40 && $urandom_range(0, 3) == 0) req = pick_request();
					c = make_cmd(1'b1, 16'($urandom()), 16'($urandom()), req, next_heading());
				end
				push_cmd(c);
				sent += c.remote_mode;
			end
		end
	endtask

	initial begin
		hhs_cmd_t c;
		int       ph;
		int       kind;
		arst_n    <= 1'b0;
		cmd_valid <= 1'b0;
		cmd       <= '0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_pace(PACE_FREE);
		c = random_cmd();
		c.remote_mode = 1'b0;
		push_cmd(c);
		push_cmd(make_cmd(1'b1, 16'sh7FFF, -16'sh8000, 16'sd0, 24'sd0));
		push_cmd(make_cmd(1'b1, -16'sh8000, 16'sh7FFF, 16'sd0, HEADING_MAX));
		push_cmd(make_cmd(1'b1, 16'sd0, -16'sd1, 16'sd0, HEADING_MIN));
		push_cmd(make_cmd(1'b1, -16'sd1, 16'sd0, 16'sh7FFF, 24'sd100));
		push_cmd(make_cmd(1'b1, 16'sd5, 16'sd7, -16'sh8000, 24'sd100));
		push_cmd(make_cmd(1'b1, 16'sd5, 16'sd7, -16'sh8000, 24'sd120));
		push_cmd(make_cmd(1'b1, 16'sd9, -16'sd9, 16'sd3, -24'sd40));
		push_cmd(make_cmd(1'b1, 16'sd9, -16'sd9, 16'sd0, -24'sd30));
		push_cmd(make_cmd(1'b1, 16'sd1, 16'sd2, 16'sd2, -24'sd30));
		push_cmd(make_cmd(1'b1, 16'sd1, 16'sd2, 16'sd0, 24'sd500));
		c = make_cmd(1'b0, 16'sd3, 16'sd3, 16'sd77, 24'sd9);
		push_cmd(c);
		push_cmd(make_cmd(1'b1, 16'sd3, 16'sd4, 16'sd0, 24'sd560));
		push_cmd(make_cmd(1'b1, 16'sd3, 16'sd4, 16'sd0, 24'sd440));
		push_cmd(make_cmd(1'b1, 16'sd3, 16'sd4, 16'sd0, 24'sd500));
		push_cmd(make_cmd(1'b1, 16'sd3, 16'sd4, 16'sd0, -24'sd2000));

		for (ph = 0; ph < 8; ph++) begin
			kind = (ph + ph / 4) % 4;
			wait_quiet();
			load_settings(kind, ph >= 4);
			set_pace(ph % 4);
			if (kind == SET_WINDUP) wind_integral(ph < 4);
			run_traffic(PHASE_ITEMS);
		end

		wait_quiet();
		if (errors == 0 && outstanding == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/hhs_pkg.sv
hw/rtl/hhs_regs.sv
hw/rtl/hhs_state.sv
hw/rtl/hhs_pid.sv
hw/rtl/heading_hold_spin_controller.sv
bench/hhs_spin_checker.sv
bench/tb_top.sv
